FILE: src/pcr_pkg.sv
// pcr_pkg: shared types and constants for the pre-trigger capture ring.
// Used by pcr_cmd_fifo, pcr_front, pcr_back and the core; no dependencies.
package pcr_pkg;

    localparam int unsigned TAIL_LIMIT     = 64;  // max stored words replayed per capture
    localparam int unsigned CMD_FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_START   = 2'd1,
        OP_CANCEL  = 2'd2,
        OP_OVERRUN = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERRUN   = 2'd1,
        ST_ZERO_LEN  = 2'd2,
        ST_CANCELLED = 2'd3
    } t_status;

    typedef enum logic {
        CMD_EMIT = 1'b0,   // one finished result
        CMD_TAIL = 1'b1    // replay of stored words
    } t_kind;

    // For CMD_TAIL: word holds the first history index, position the word
    // count, last says the tail closes the capture.
    typedef struct packed {
        t_kind       kind;
        logic        has_word;
        logic [31:0] word;
        logic [15:0] position;
        logic        last;
        t_status     status;
    } t_cmd;

    typedef struct packed {
        logic tail_active;
        logic tail_done;
    } t_back_stat;

endpackage

FILE: src/pcr_ram.sv
// pcr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/pcr_cmd_fifo.sv
// pcr_cmd_fifo: short command queue between front and back.
// Depends on pcr_pkg (t_cmd, CMD_FIFO_DEPTH).
module pcr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pcr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pcr_pkg::t_cmd o_cmd
);

    localparam int PW = $clog2(pcr_pkg::CMD_FIFO_DEPTH);
    localparam int CW = $clog2(pcr_pkg::CMD_FIFO_DEPTH + 1);

    pcr_pkg::t_cmd r_mem [pcr_pkg::CMD_FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(pcr_pkg::CMD_FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(pcr_pkg::CMD_FIFO_DEPTH - 1)) ? '0
                                                                            : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(pcr_pkg::CMD_FIFO_DEPTH - 1)) ? '0
                                                                            : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("cmd fifo: push while full");

endmodule

FILE: src/pcr_front.sv
// pcr_front: accepts requests, keeps history pointers and capture state,
// writes samples to the history RAM and queues result commands.
// Depends on pcr_pkg.
module pcr_front #(
    parameter int HISTORY_DEPTH = 64,
    parameter int MAX_CAPTURE   = 65535
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  logic [6:0]                       i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  pcr_pkg::t_op                     i_op,
    input  logic [31:0]                      i_sample_word,
    input  logic [15:0]                      i_capture_length,
    output logic                             o_wr_en,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_wr_addr,
    output logic [31:0]                      o_wr_data,
    output logic                             o_push,
    output pcr_pkg::t_cmd                    o_cmd,
    input  logic                             i_fifo_full,
    input  pcr_pkg::t_back_stat              i_bstat
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int EW = (AW + 1 > 7) ? AW + 1 : 7;
    localparam logic [23:0] MAX_LEN = 24'(MAX_CAPTURE);

    logic [6:0]    r_pre_cfg;
    logic [AW-1:0] r_wp;
    logic [FW-1:0] r_fill;
    logic          r_busy;
    logic [15:0]   r_total;
    logic [15:0]   r_done;
    logic          r_ovr;
    logic          r_tail_pend;

    logic          accept;
    logic [15:0]   len_sat;
    logic [6:0]    pre_a, pre_b, pre;
    logic [EW-1:0] start_e;
    logic [15:0]   done_inc;
    logic          live_last;

    assign o_ready = !i_fifo_full && !r_tail_pend;
    assign accept  = i_valid && o_ready;

    always_comb begin
        len_sat = ({8'd0, i_capture_length} > MAX_LEN) ? MAX_LEN[15:0] : i_capture_length;
        pre_a   = (r_pre_cfg > 7'(pcr_pkg::TAIL_LIMIT)) ? 7'(pcr_pkg::TAIL_LIMIT) : r_pre_cfg;
        pre_b   = (EW'(r_fill) < EW'(pre_a)) ? 7'(r_fill) : pre_a;
        pre     = ({9'd0, pre_b} > len_sat) ? len_sat[6:0] : pre_b;
        // oldest tail word sits pre entries behind the write pointer
        start_e = (EW'(r_wp) >= EW'(pre)) ? EW'(r_wp) - EW'(pre)
                                          : EW'(r_wp) + EW'(HISTORY_DEPTH) - EW'(pre);
        done_inc  = r_done + 16'd1;
        live_last = (done_inc >= r_total);
    end

    assign o_wr_en   = accept && (i_op == pcr_pkg::OP_SAMPLE);
    assign o_wr_addr = r_wp;
    assign o_wr_data = i_sample_word;

    always_comb begin
        o_push = 1'b0;
        o_cmd  = '{kind: pcr_pkg::CMD_EMIT, has_word: 1'b0, word: '0, position: '0,
                   last: 1'b0, status: pcr_pkg::ST_OK};
        if (accept) begin
            unique case (i_op)
                pcr_pkg::OP_SAMPLE: begin
                    o_push          = r_busy;
                    o_cmd.has_word  = 1'b1;
                    o_cmd.word      = i_sample_word;
                    o_cmd.position  = r_done;
                    o_cmd.last      = live_last;
                    if (live_last && r_ovr) begin
                        o_cmd.status = pcr_pkg::ST_OVERRUN;
                    end
                end
                pcr_pkg::OP_START: begin
                    if (i_capture_length == '0) begin
                        o_push       = 1'b1;
                        o_cmd.last   = 1'b1;
                        o_cmd.status = pcr_pkg::ST_ZERO_LEN;
                    end else begin
                        o_push         = (pre != '0);
                        o_cmd.kind     = pcr_pkg::CMD_TAIL;
                        o_cmd.has_word = 1'b1;
                        o_cmd.word     = 32'(start_e[AW-1:0]);
                        o_cmd.position = 16'(pre);
                        o_cmd.last     = ({9'd0, pre} >= len_sat);
                    end
                end
                pcr_pkg::OP_CANCEL: begin
                    o_push         = r_busy;
                    o_cmd.position = r_done;
                    o_cmd.last     = 1'b1;
                    o_cmd.status   = pcr_pkg::ST_CANCELLED;
                end
                pcr_pkg::OP_OVERRUN: begin
                    o_push = 1'b0;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_cfg   <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_total     <= '0;
            r_done      <= '0;
            r_ovr       <= 1'b0;
            r_tail_pend <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_pre_cfg <= i_cfg_wdata;
            end
            if (i_bstat.tail_done) begin
                r_tail_pend <= 1'b0;
            end
            if (accept) begin
                unique case (i_op)
                    pcr_pkg::OP_SAMPLE: begin
                        r_wp <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        if (r_fill != FW'(HISTORY_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        if (r_busy) begin
                            r_done <= done_inc;
                            if (live_last) begin
                                r_busy <= 1'b0;
                            end
                        end
                    end
                    pcr_pkg::OP_START: begin
                        if (i_capture_length != '0) begin
                            r_total     <= len_sat;
                            r_done      <= 16'(pre);
                            r_ovr       <= 1'b0;
                            r_busy      <= ({9'd0, pre} < len_sat);
                            r_tail_pend <= (pre != '0);
                        end
                    end
                    pcr_pkg::OP_CANCEL: begin
                        r_busy <= 1'b0;
                    end
                    pcr_pkg::OP_OVERRUN: begin
                        if (r_busy) begin
                            r_ovr <= 1'b1;
                        end
                    end
                    default: begin
                        r_busy <= r_busy;
                    end
                endcase
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(HISTORY_DEPTH))
        else $error("front: fill count above history depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_done < r_total))
        else $error("front: active capture already complete");

endmodule

FILE: src/pcr_back.sv
// pcr_back: executes queued commands, replays tail words from the history
// RAM and holds the output register. Depends on pcr_pkg.
module pcr_back #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    input  pcr_pkg::t_cmd                    i_cmd,
    output logic                             o_pop,
    output logic                             o_rd_en,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_rd_addr,
    input  logic [31:0]                      i_rd_data,
    output pcr_pkg::t_back_stat              o_bstat,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_has_word,
    output logic [31:0]                      o_word,
    output logic [15:0]                      o_position,
    output logic                             o_last,
    output pcr_pkg::t_status                 o_status
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAIL_RD,
        S_TAIL_OUT
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_addr;
    logic [6:0]       r_pos;
    logic [6:0]       r_cnt;
    logic             r_fin;
    logic             r_valid;
    logic             r_has_word;
    logic [31:0]      r_word;
    logic [15:0]      r_position;
    logic             r_last;
    pcr_pkg::t_status r_status;

    logic       out_free;
    logic [6:0] pos_inc;
    logic       tail_end;
    logic       load_out;

    assign out_free = !r_valid || i_ready;
    assign pos_inc  = r_pos + 7'd1;
    assign tail_end = (pos_inc == r_cnt);

    assign o_pop     = (r_state == S_IDLE) && i_cmd_valid && out_free;
    assign o_rd_en   = (r_state == S_TAIL_RD);
    assign o_rd_addr = r_addr;

    // output register takes a new result this cycle
    assign load_out = (o_pop && (i_cmd.kind == pcr_pkg::CMD_EMIT))
                   || ((r_state == S_TAIL_OUT) && out_free);

    assign o_bstat.tail_active = (r_state != S_IDLE);
    assign o_bstat.tail_done   = (r_state == S_TAIL_OUT) && out_free && tail_end;

    assign o_valid    = r_valid;
    assign o_has_word = r_has_word;
    assign o_word     = r_word;
    assign o_position = r_position;
    assign o_last     = r_last;
    assign o_status   = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_cmd.kind == pcr_pkg::CMD_EMIT) begin
                            r_has_word <= i_cmd.has_word;
                            r_word     <= i_cmd.word;
                            r_position <= i_cmd.position;
                            r_last     <= i_cmd.last;
                            r_status   <= i_cmd.status;
                        end else begin
                            r_addr  <= i_cmd.word[AW-1:0];
                            r_cnt   <= i_cmd.position[6:0];
                            r_fin   <= i_cmd.last;
                            r_pos   <= '0;
                            r_state <= S_TAIL_RD;
                        end
                    end
                end
                S_TAIL_RD: begin
                    r_state <= S_TAIL_OUT;
                end
                S_TAIL_OUT: begin
                    if (out_free) begin
                        r_has_word <= 1'b1;
                        r_word     <= i_rd_data;
                        r_position <= 16'(r_pos);
                        r_last     <= tail_end && r_fin;
                        r_status   <= pcr_pkg::ST_OK;
                        if (tail_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= pos_inc;
                            r_addr  <= (r_addr == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                          : r_addr + 1'b1;
                            r_state <= S_TAIL_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cnt != '0) && (r_pos < r_cnt))
        else $error("back: tail position outside its count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_has_word) |-> r_last)
        else $error("back: status-only result without last");

endmodule

FILE: src/pretrigger_capture_ring_core.sv
// pretrigger_capture_ring_core: top level of the pre-trigger capture ring.
// Depends on pcr_pkg, pcr_ram, pcr_cmd_fifo, pcr_front, pcr_back.
//
//  channel  dir  handshake              payload
//  s        in   i_s_tvalid/o_s_tready  tdata {capture_length, sample_word}, tuser op
//  m        out  o_m_tvalid/i_m_tready  tdata {position, captured_word},
//                                       tuser {status, has_word}, tlast last
//  cfg      in   i_cfg_wen              i_cfg_wdata = pre_trigger_count
//
// Sample, cancel and overrun requests are taken one per cycle while o_s_tready is
// high; the front stalls when the two-entry command queue is full or a tail replay
// is pending. A start replays its stored tail word by word (registered RAM read,
// then output register); the front holds o_s_tready low until the last tail
// word has been loaded, so the history cannot be overwritten mid-replay.
// Reset (i_rst_n low, synchronous) clears pointers, fill count, capture state,
// queue and output valid; history contents are never read before written.
// A stalled m side backs up into the queue and then into s; nothing is dropped.
module pretrigger_capture_ring_core #(
    parameter int HISTORY_DEPTH = 64,
    parameter int MAX_CAPTURE   = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [31:0] sample_word, [47:32] capture_length
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [31:0] captured_word, [47:32] position
    output logic [2:0]  o_m_tuser,   // [0] has_word, [2:1] status
    output logic        o_m_tlast
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    // history RAM ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;

    // command queue
    logic          push;
    logic          pop;
    logic          fifo_full;
    logic          cmd_valid;
    pcr_pkg::t_cmd push_cmd;
    pcr_pkg::t_cmd head_cmd;

    pcr_pkg::t_back_stat bstat;

    logic             has_word;
    logic [31:0]      word;
    logic [15:0]      position;
    pcr_pkg::t_status status;

    pcr_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_CAPTURE   (MAX_CAPTURE)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wen        (i_cfg_wen),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_op             (pcr_pkg::t_op'(i_s_tuser)),
        .i_sample_word    (i_s_tdata[31:0]),
        .i_capture_length (i_s_tdata[47:32]),
        .o_wr_en          (wr_en),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data),
        .o_push           (push),
        .o_cmd            (push_cmd),
        .i_fifo_full      (fifo_full),
        .i_bstat          (bstat)
    );

    pcr_ram #(
        .WIDTH (32),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pcr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd)
    );

    pcr_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_bstat     (bstat),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_has_word  (has_word),
        .o_word      (word),
        .o_position  (position),
        .o_last      (o_m_tlast),
        .o_status    (status)
    );

    assign o_m_tdata = {position, word};
    assign o_m_tuser = {status, has_word};

    // while a tail is replayed the history must not move
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.tail_active |-> !o_s_tready)
        else $error("core: request accepted during tail replay");

endmodule
